// ===== rtl/swpg_pkg.sv =====
// Package for the square-wave generator: types, reset values and widths.
// Used by swpg_ctrl, swpg_dp and square_wave_pulse_generator_unit.
`timescale 1ns / 1ps
package swpg_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned StepWidth    = $clog2(DataWidth);

  localparam logic [DataWidth-1:0] ClockReset = 32'd200000000;
  localparam logic [DataWidth-1:0] MaxFReset  = 32'd1000000;

  typedef enum logic {
    REG_TIMER_CLOCK = 1'b0,
    REG_MAX_FREQ    = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SET  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic tick;
    logic stop;
    logic div_start;
    logic div_step;
    logic finish;
  } swpg_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic out_free;
  } swpg_sts_t;

endpackage

// ===== rtl/swpg_ctrl.sv =====
// Controller state machine: word acceptance and sequencing of the divider.
// Depends on swpg_pkg; drives swpg_dp through swpg_cmd_t.
`timescale 1ns / 1ps
module swpg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  swpg_pkg::swpg_sts_t sts_i,
  output swpg_pkg::swpg_cmd_t cmd_o
);
  import swpg_pkg::*;

  localparam logic [StepWidth-1:0] LastStep = StepWidth'(DataWidth - 1);

  state_e               state_q, state_d;
  logic [StepWidth-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (action_i == ACT_TICK) begin
            cmd_o.tick = 1'b1;
          end else if (sts_i.freq_zero) begin
            cmd_o.stop = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            step_d          = '0;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == LastStep) |=> (state_q == ST_FINISH))
    else $error("divider did not finish after last step");
  a_div_begins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == ST_DIV && step_q == '0))
    else $error("divider did not start from step zero");
`endif

endmodule

// ===== rtl/swpg_dp.sv =====
// Datapath: configuration registers, clamp, shift-subtract divider,
// period counter and output register. Depends on swpg_pkg.
`timescale 1ns / 1ps
module swpg_dp #(
  parameter int unsigned COUNT_WIDTH = swpg_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [swpg_pkg::DataWidth-1:0]   cfg_data_i,
  input  logic [swpg_pkg::DataWidth-1:0]   requested_hz_i,
  input  swpg_pkg::swpg_cmd_t              cmd_i,
  output swpg_pkg::swpg_sts_t              sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             pin_level_o,
  output logic                             running_o,
  output logic [swpg_pkg::DataWidth-1:0]   current_hz_o
);
  import swpg_pkg::*;

  localparam logic [DataWidth-1:0] CountMax = DataWidth'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [DataWidth-1:0]   clock_q, maxf_q;
  logic [DataWidth-1:0]   freq_clamped;
  logic [DataWidth-1:0]   rem_q, rem_d, quo_q, quo_d, den_q;
  logic [DataWidth:0]     rem_shift, rem_diff;
  logic [DataWidth-1:0]   period_full, period_sat;
  logic [COUNT_WIDTH-1:0] period_new;
  logic [COUNT_WIDTH:0]   period_inc;
  logic [COUNT_WIDTH-1:0] compare_new;
  logic [COUNT_WIDTH-1:0] count_q, period_q, compare_q;
  logic [DataWidth-1:0]   active_q;
  logic                   enabled_q;
  logic                   out_valid_q, pin_q;
  logic                   tick_pin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= ClockReset;
      maxf_q  <= MaxFReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TIMER_CLOCK) begin
        clock_q <= cfg_data_i;
      end else begin
        maxf_q <= cfg_data_i;
      end
    end
  end

  assign freq_clamped    = (requested_hz_i > maxf_q) ? maxf_q : requested_hz_i;
  assign sts_o.freq_zero = (freq_clamped == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // restoring divide, one quotient bit per cycle
  assign rem_shift = {rem_q, quo_q[DataWidth-1]};
  assign rem_diff  = rem_shift - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = clock_q;
    end else if (cmd_i.div_step) begin
      if (!rem_diff[DataWidth]) begin
        rem_d = rem_diff[DataWidth-1:0];
        quo_d = {quo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DataWidth-1:0];
        quo_d = {quo_q[DataWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.div_start) begin
      den_q <= freq_clamped;
    end
  end

  assign period_full = (quo_q == '0) ? '0 : quo_q - 1'b1;
  assign period_sat  = (period_full > CountMax) ? CountMax : period_full;
  assign period_new  = period_sat[COUNT_WIDTH-1:0];
  assign period_inc  = {1'b0, period_new} + 1'b1;
  assign compare_new = period_inc[COUNT_WIDTH:1];

  assign tick_pin = enabled_q && (count_q < compare_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      period_q  <= '0;
      compare_q <= '0;
      active_q  <= '0;
      enabled_q <= 1'b0;
    end else if (cmd_i.finish) begin
      count_q   <= '0;
      period_q  <= period_new;
      compare_q <= compare_new;
      active_q  <= den_q;
      enabled_q <= 1'b1;
    end else if (cmd_i.stop) begin
      active_q  <= '0;
      enabled_q <= 1'b0;
    end else if (cmd_i.tick && enabled_q) begin
      if (count_q >= period_q) begin
        count_q <= '0;
      end else begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick || cmd_i.stop || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      pin_q <= tick_pin;
    end else if (cmd_i.stop) begin
      pin_q <= 1'b0;
    end else if (cmd_i.finish) begin
      pin_q <= (compare_new != '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pin_level_o  = pin_q;
  assign running_o    = enabled_q;
  assign current_hz_o = active_q;

`ifndef ASSERT_OFF
  a_count_in_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= period_q)
    else $error("tick counter beyond period");
  a_stopped_no_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enabled_q |-> (active_q == '0))
    else $error("frequency held while stopped");
`endif

endmodule

// ===== rtl/square_wave_pulse_generator_unit.sv =====
// Top level of the 50% square-wave generator.
// Depends on swpg_pkg, swpg_ctrl and swpg_dp.
`timescale 1ns / 1ps
// Input channel (in_valid_i/in_ready_o) carries one word per item: action_i
// 0 is a timer tick, action_i 1 sets the output frequency from requested_hz_i.
// Each word gives one result word on the output channel (out_valid_o /
// out_ready_i): pin_level_o, running_o and current_hz_o.
// Results of ticks and stop requests are registered on the accepting edge; a
// new word is taken every cycle while the output register is empty or being
// drained. A nonzero frequency request runs a shift-subtract divide, one
// quotient bit per cycle, then a finish state derives period and compare
// and registers the result; no further word is taken before that.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 timer
// clock in Hz, 1 frequency clamp in Hz); the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Reset stops the generator, clears counter, period and compare, and loads
// a 200 MHz timer clock and a 1 MHz clamp.
// When the receiver stalls, the result stays on the output and in_ready_o
// drops until it is taken.
module square_wave_pulse_generator_unit #(
  parameter int unsigned COUNT_WIDTH = swpg_pkg::CountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [swpg_pkg::DataWidth-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [swpg_pkg::DataWidth-1:0] requested_hz_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           pin_level_o,
  output logic                           running_o,
  output logic [swpg_pkg::DataWidth-1:0] current_hz_o
);
  import swpg_pkg::*;

  swpg_cmd_t cmd;
  swpg_sts_t sts;

  swpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swpg_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .requested_hz_i (requested_hz_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pin_level_o    (pin_level_o),
    .running_o      (running_o),
    .current_hz_o   (current_hz_o)
  );

endmodule
